@@ rtl/kmhc_pkg.sv @@
// shared types and constants for the keypad hold counter
`timescale 1ns / 1ps
`default_nettype none

package kmhc_pkg;

    localparam int OP_BITS = 2;
    localparam int ROW_FIELD_BITS = 4;
    localparam int KEY_IDX_BITS = 2;
    localparam int DRIVE_BITS = 4;
    localparam int VALUE_BITS = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_SCAN  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    // per-lane control for one cycle
    typedef struct packed {
        logic scan_en;
        logic write_en;
        logic pressed;
    } lane_ctl_t;

endpackage

`default_nettype wire

@@ rtl/kmhc_ifs.sv @@
// valid/ready channel interfaces for item words and result words
`timescale 1ns / 1ps
`default_nettype none

interface kmhc_in_if;
    logic                                valid;
    logic                                ready;
    logic [kmhc_pkg::OP_BITS-1:0]        op;
    logic [kmhc_pkg::ROW_FIELD_BITS-1:0] row_levels;
    logic [kmhc_pkg::KEY_IDX_BITS-1:0]   key_col;
    logic [kmhc_pkg::KEY_IDX_BITS-1:0]   key_row;
    logic [kmhc_pkg::VALUE_BITS-1:0]     write_value;

    modport source (output valid, op, row_levels, key_col, key_row, write_value,
                    input ready);
    modport sink (input valid, op, row_levels, key_col, key_row, write_value,
                  output ready);
endinterface

interface kmhc_out_if;
    logic                            valid;
    logic                            ready;
    logic [kmhc_pkg::DRIVE_BITS-1:0] column_drive;
    logic [kmhc_pkg::VALUE_BITS-1:0] read_value;

    modport source (output valid, column_drive, read_value, input ready);
    modport sink (input valid, column_drive, read_value, output ready);
endinterface

`default_nettype wire

@@ rtl/kmhc_row_lane.sv @@
// hold counters of one keypad row, one per column, saturating
`timescale 1ns / 1ps
`default_nettype none

module kmhc_row_lane #(
    parameter int COLUMNS = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [(COLUMNS > 1 ? $clog2(COLUMNS) : 1)-1:0] addr,
    input  wire kmhc_pkg::lane_ctl_t                   ctl,
    input  wire logic [COUNT_WIDTH-1:0]                write_count,
    output logic [COUNT_WIDTH-1:0]                     count
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] cnt_reg [COLUMNS];
    logic [COUNT_WIDTH-1:0] cnt_next;

    assign count = cnt_reg[addr];

    always_comb
    begin
        if (ctl.write_en)
        begin
            cnt_next = write_count;
        end
        else if (ctl.pressed)
        begin
            // saturate at the top
            cnt_next = (count == COUNT_MAX) ? count : count + COUNT_WIDTH'(1);
        end
        else
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COLUMNS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (ctl.scan_en || ctl.write_en)
        begin
            cnt_reg[addr] <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/keypad_matrix_hold_counter.sv @@
// keypad matrix hold counter: top level with input and result registers
//
// item channel: op 0 scans the current column with the sampled active-low
// row levels, op 1 reads the hold count of key (key_col, key_row), op 2
// writes write_value into that key's count. op 3 changes nothing.
// result channel: one word per item, column_drive is the active-low pattern
// for the column the next scan uses, read_value the count on a read, else 0.
// a taken word is held in the input register and its result in the result register.
// throughput: one item per cycle while results are taken; every counter of the scanned column is
// updated in the same cycle by its own row lane.
// a stalled result holds in the output register; one more item waits in the
// input register, then ready drops until the receiver takes the result.
// reset clears the column pointer to column 0 and every hold count to zero.
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_hold_counter #(
    parameter int COLUMNS = 4,
    parameter int ROWS = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    kmhc_in_if.sink     item,
    kmhc_out_if.source  result
);

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KCOL_W = (COL_W > kmhc_pkg::KEY_IDX_BITS) ? COL_W : kmhc_pkg::KEY_IDX_BITS;
    localparam int KROW_W = (ROW_W > kmhc_pkg::KEY_IDX_BITS) ? ROW_W : kmhc_pkg::KEY_IDX_BITS;

    // input register
    logic                                   in_valid_reg;
    logic [kmhc_pkg::OP_BITS-1:0]           op_reg;
    logic [kmhc_pkg::ROW_FIELD_BITS-1:0]    levels_reg;
    logic [kmhc_pkg::KEY_IDX_BITS-1:0]      key_col_reg;
    logic [kmhc_pkg::KEY_IDX_BITS-1:0]      key_row_reg;
    logic [kmhc_pkg::VALUE_BITS-1:0]        wval_reg;

    // result register
    logic                                   out_valid_reg;
    logic [kmhc_pkg::DRIVE_BITS-1:0]        drive_reg;
    logic [kmhc_pkg::VALUE_BITS-1:0]        rdval_reg;

    logic [COL_W-1:0]                       scan_col_reg;
    logic [COL_W-1:0]                       scan_col_next;

    logic                                   advance;
    logic                                   is_scan;
    logic                                   is_read;
    logic                                   is_write;
    logic                                   key_ok;
    logic [KCOL_W-1:0]                      kcol_ext;
    logic [KROW_W-1:0]                      krow_ext;
    logic [COL_W-1:0]                       key_col_idx;
    logic [ROW_W-1:0]                       key_row_idx;
    logic [COL_W-1:0]                       lane_addr;
    logic [COL_W-1:0]                       col_after;
    logic [COUNT_WIDTH-1:0]                 lane_count [ROWS];
    logic [COUNT_WIDTH-1:0]                 sel_count;
    logic [kmhc_pkg::DRIVE_BITS-1:0]        drive_next;
    logic [kmhc_pkg::VALUE_BITS-1:0]        rdval_next;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign is_scan  = (op_reg == kmhc_pkg::OP_SCAN);
    assign is_read  = (op_reg == kmhc_pkg::OP_READ);
    assign is_write = (op_reg == kmhc_pkg::OP_WRITE);

    assign key_ok = (int'(key_col_reg) < COLUMNS) && (int'(key_row_reg) < ROWS);
    assign kcol_ext = KCOL_W'(key_col_reg);
    assign krow_ext = KROW_W'(key_row_reg);
    assign key_col_idx = kcol_ext[COL_W-1:0];
    assign key_row_idx = krow_ext[ROW_W-1:0];

    assign lane_addr = is_scan ? scan_col_reg : key_col_idx;

    assign scan_col_next = (int'(scan_col_reg) == COLUMNS - 1) ? '0
                                                               : scan_col_reg + COL_W'(1);
    assign col_after = is_scan ? scan_col_next : scan_col_reg;

    genvar r;
    generate
        for (r = 0; r < ROWS; r++)
        begin : g_lane
            kmhc_pkg::lane_ctl_t ctl;

            assign ctl.scan_en  = advance && is_scan;
            assign ctl.write_en = advance && is_write && key_ok && (int'(key_row_idx) == r);
            // rows past the level field read as released
            if (r < kmhc_pkg::ROW_FIELD_BITS)
            begin : g_sampled
                assign ctl.pressed = !levels_reg[r] && !is_write;
            end
            else
            begin : g_unsampled
                assign ctl.pressed = 1'b0;
            end

            kmhc_row_lane #(
                .COLUMNS     (COLUMNS),
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .addr        (lane_addr),
                .ctl         (ctl),
                .write_count (COUNT_WIDTH'(wval_reg)),
                .count       (lane_count[r])
            );
        end
    endgenerate

    assign sel_count = lane_count[key_row_idx];

    always_comb
    begin
        for (int i = 0; i < kmhc_pkg::DRIVE_BITS; i++)
        begin
            drive_next[i] = !(int'(col_after) == i);
        end
        rdval_next = (is_read && key_ok) ? kmhc_pkg::VALUE_BITS'(sel_count) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_col_reg  <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && is_scan)
            begin
                scan_col_reg <= scan_col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            op_reg      <= item.op;
            levels_reg  <= item.row_levels;
            key_col_reg <= item.key_col;
            key_row_reg <= item.key_row;
            wval_reg    <= item.write_value;
        end
        if (advance)
        begin
            drive_reg <= drive_next;
            rdval_reg <= rdval_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.column_drive = drive_reg;
    assign result.read_value   = rdval_reg;

endmodule

`default_nettype wire
